// ===== hdl/sha1mh_pkg.sv =====
// shared types, constants and round functions for the sha-1 message hash
`timescale 1ns / 1ps
`default_nettype none

package sha1mh_pkg;

    localparam int CNT_BITS     = 61;
    localparam int LEN_BITS     = 64;
    localparam int BLK_WORDS    = 16;
    localparam int ROUNDS       = 80;
    localparam int DIGEST_WORDS = 5;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [31:0] K_0      = 32'h5A827999;
    localparam logic [31:0] K_1      = 32'h6ED9EBA1;
    localparam logic [31:0] K_2      = 32'h8F1BBCDC;
    localparam logic [31:0] K_3      = 32'hCA62C1D6;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
    } op_t;

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] h;
        case (idx)
            3'd0:    h = 32'h67452301;
            3'd1:    h = 32'hEFCDAB89;
            3'd2:    h = 32'h98BADCFE;
            3'd3:    h = 32'h10325476;
            default: h = 32'hC3D2E1F0;
        endcase
        return h;
    endfunction

    // lane 0 opens the word and clears the lower bytes
    function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [1:0] lane,
                                             input logic [7:0] b);
        logic [31:0] w;
        case (lane)
            2'd0:    w = {b, 24'h000000};
            2'd1:    w = {word[31:24], b, word[15:0]};
            2'd2:    w = {word[31:16], b, word[7:0]};
            default: w = {word[31:8], b};
        endcase
        return w;
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] r);
        logic [31:0] k;
        if (r < 7'd20)
            k = K_0;
        else if (r < 7'd40)
            k = K_1;
        else if (r < 7'd60)
            k = K_2;
        else
            k = K_3;
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (r < 7'd20)
            f = (b & c) | (~b & d);
        else if (r < 7'd40)
            f = b ^ c ^ d;
        else if (r < 7'd60)
            f = (b & c) | (b & d) | (c & d);
        else
            f = b ^ c ^ d;
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sha1_message_hash.sv =====
// top level of the sha-1 message hash: input stage, item queue and hash engine
//
// One message byte per input item, big-endian packed into 64-byte blocks. The engine
// takes byte items only while idle; the 64th byte of a block starts the compression,
// which runs one round per cycle for 80 rounds and then folds the result into the
// hash. The item that ends the message adds a padding step, a length step and one
// (or, when 56 or more bytes sit in the last block, two) compressions, then five
// digest words, most significant first, at one per cycle while the output is taken.
// The single-round compression loop sets the rate. A two-entry queue lets the input
// take items while the engine compresses. The bit length wraps modulo 2^64.
`timescale 1ns / 1ps
`default_nettype none

module sha1_message_hash (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        has_byte,
    input  wire logic        is_last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);
    import sha1mh_pkg::*;

    op_t  front_op;
    logic front_valid;
    logic front_ready;
    op_t  queue_op;
    logic queue_valid;
    logic queue_ready;

    sha1mh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .has_byte  (has_byte),
        .is_last   (is_last),
        .op_valid  (front_valid),
        .op_ready  (front_ready),
        .op        (front_op)
    );

    sha1mh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_op    (front_op),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_op     (queue_op)
    );

    sha1mh_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .op_valid    (queue_valid),
        .op_ready    (queue_ready),
        .op          (queue_op),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

endmodule

`default_nettype wire

// ===== hdl/sha1mh_front.sv =====
// input stage: takes items, drops empty ones, passes byte and end marks on
`timescale 1ns / 1ps
`default_nettype none

module sha1mh_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       data_byte,
    input  wire logic             has_byte,
    input  wire logic             is_last,
    output logic                  op_valid,
    input  wire logic             op_ready,
    output sha1mh_pkg::op_t       op
);
    import sha1mh_pkg::*;

    logic valid_reg;
    logic valid_next;
    op_t  op_reg;
    logic take;
    logic keep;

    assign in_ready = !valid_reg || op_ready;
    assign take     = in_valid && in_ready;
    // an item with neither a byte nor an end mark has no effect
    assign keep     = has_byte || is_last;

    always_comb
    begin
        valid_next = valid_reg && !op_ready;
        if (take)
            valid_next = keep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && keep)
            op_reg <= '{data: data_byte, has: has_byte, last: is_last};
    end

    assign op_valid = valid_reg;
    assign op       = op_reg;

endmodule

`default_nettype wire

// ===== hdl/sha1mh_queue.sv =====
// small item queue between the input stage and the hash engine
`timescale 1ns / 1ps
`default_nettype none

module sha1mh_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire sha1mh_pkg::op_t  push_op,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output sha1mh_pkg::op_t       pop_op
);
    import sha1mh_pkg::*;

    op_t                  mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] cnt_reg;
    logic [QCNT_BITS-1:0] cnt_next;
    logic                 push;
    logic                 pop;

    assign push_ready = cnt_reg != QCNT_BITS'(QUEUE_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_op     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_BITS'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_BITS'(1);
        if (push && !pop)
            cnt_next = cnt_reg + QCNT_BITS'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QCNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_op;
    end

endmodule

`default_nettype wire

// ===== hdl/sha1mh_engine.sv =====
// hash engine: block packing, padding, 80-round compression and digest output
`timescale 1ns / 1ps
`default_nettype none

module sha1mh_engine (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             op_valid,
    output logic                  op_ready,
    input  wire sha1mh_pkg::op_t  op,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [31:0]           digest_word,
    output logic [2:0]            word_index,
    output logic                  last_word
);
    import sha1mh_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ROUND = 6'b000010,
        ST_FOLD  = 6'b000100,
        ST_PAD   = 6'b001000,
        ST_LEN   = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        BK_DATA,
        BK_OVER,
        BK_FINAL
    } blk_kind_t;

    state_t              state_reg, state_next;
    blk_kind_t           kind_reg, kind_next;
    logic                last_pend_reg, last_pend_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [6:0]          round_reg, round_next;
    logic [2:0]          emit_idx_reg, emit_idx_next;
    logic [31:0]         hash_reg [DIGEST_WORDS];
    logic [31:0]         hash_next [DIGEST_WORDS];
    logic [31:0]         work_reg [DIGEST_WORDS];
    logic [31:0]         work_next [DIGEST_WORDS];
    logic [31:0]         blk_reg [BLK_WORDS];
    logic [31:0]         blk_next [BLK_WORDS];
    logic                out_valid_reg, out_valid_next;
    logic [31:0]         digest_reg, digest_next;
    logic [2:0]          index_reg, index_next;
    logic                last_reg, last_next;

    logic [5:0]          pos;
    logic [LEN_BITS-1:0] bit_len;
    logic [31:0]         sched;
    logic [31:0]         wt;
    logic [31:0]         tmp;
    logic                out_load;

    assign pos     = count_reg[5:0];
    assign bit_len = {{(LEN_BITS - CNT_BITS){1'b0}}, count_reg} << 3;
    assign sched   = blk_reg[13] ^ blk_reg[8] ^ blk_reg[2] ^ blk_reg[0];
    assign wt      = (round_reg < 7'd16) ? blk_reg[0] : {sched[30:0], sched[31]};
    assign tmp     = {work_reg[0][26:0], work_reg[0][31:27]}
                   + round_f(round_reg, work_reg[1], work_reg[2], work_reg[3])
                   + work_reg[4] + round_k(round_reg) + wt;
    assign op_ready = state_reg == ST_IDLE;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        last_pend_next = last_pend_reg;
        count_next     = count_reg;
        round_next     = round_reg;
        emit_idx_next  = emit_idx_reg;
        hash_next      = hash_reg;
        work_next      = work_reg;
        blk_next       = blk_reg;
        digest_next    = digest_reg;
        index_next     = index_reg;
        last_next      = last_reg;
        out_load       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (op_valid)
                begin
                    last_pend_next = op.last;
                    if (op.has)
                    begin
                        for (int i = 0; i < BLK_WORDS; i++)
                        begin
                            if (4'(i) == pos[5:2])
                                blk_next[i] = put_byte(blk_reg[i], pos[1:0], op.data);
                        end
                        count_next = count_reg + CNT_BITS'(1);
                    end
                    if (op.has && pos == 6'd63)
                    begin
                        work_next  = hash_reg;
                        round_next = '0;
                        kind_next  = BK_DATA;
                        state_next = ST_ROUND;
                    end
                    else if (op.last)
                        state_next = ST_PAD;
                end
            end
            ST_ROUND:
            begin
                work_next[4] = work_reg[3];
                work_next[3] = work_reg[2];
                work_next[2] = {work_reg[1][1:0], work_reg[1][31:2]};
                work_next[1] = work_reg[0];
                work_next[0] = tmp;
                for (int i = 0; i < BLK_WORDS - 1; i++)
                    blk_next[i] = blk_reg[i + 1];
                blk_next[BLK_WORDS - 1] = wt;
                if (round_reg == 7'(ROUNDS - 1))
                begin
                    round_next = '0;
                    state_next = ST_FOLD;
                end
                else
                    round_next = round_reg + 7'd1;
            end
            ST_FOLD:
            begin
                for (int i = 0; i < DIGEST_WORDS; i++)
                    hash_next[i] = hash_reg[i] + work_reg[i];
                case (kind_reg)
                    BK_DATA:  state_next = last_pend_reg ? ST_PAD : ST_IDLE;
                    BK_OVER:  state_next = ST_LEN;
                    BK_FINAL:
                    begin
                        emit_idx_next = '0;
                        state_next    = ST_EMIT;
                    end
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_PAD:
            begin
                for (int i = 0; i < BLK_WORDS; i++)
                begin
                    if (4'(i) == pos[5:2])
                        blk_next[i] = put_byte(blk_reg[i], pos[1:0], PAD_BYTE);
                    else if (4'(i) > pos[5:2])
                        blk_next[i] = '0;
                end
                // no room for the length field: pad block goes out on its own
                if (pos >= 6'd56)
                begin
                    work_next  = hash_reg;
                    round_next = '0;
                    kind_next  = BK_OVER;
                    state_next = ST_ROUND;
                end
                else
                begin
                    kind_next  = BK_DATA;
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (kind_reg == BK_OVER)
                begin
                    for (int i = 0; i < BLK_WORDS - 2; i++)
                        blk_next[i] = '0;
                end
                blk_next[BLK_WORDS - 2] = bit_len[63:32];
                blk_next[BLK_WORDS - 1] = bit_len[31:0];
                work_next  = hash_reg;
                round_next = '0;
                kind_next  = BK_FINAL;
                state_next = ST_ROUND;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load    = 1'b1;
                    digest_next = hash_reg[emit_idx_reg];
                    index_next  = emit_idx_reg;
                    last_next   = emit_idx_reg == 3'(DIGEST_WORDS - 1);
                    if (emit_idx_reg == 3'(DIGEST_WORDS - 1))
                    begin
                        for (int i = 0; i < DIGEST_WORDS; i++)
                            hash_next[i] = init_hash(3'(i));
                        count_next     = '0;
                        last_pend_next = 1'b0;
                        emit_idx_next  = '0;
                        state_next     = ST_IDLE;
                    end
                    else
                        emit_idx_next = emit_idx_reg + 3'd1;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        out_valid_next = out_load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= BK_DATA;
            last_pend_reg <= 1'b0;
            count_reg     <= '0;
            round_reg     <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < DIGEST_WORDS; i++)
                hash_reg[i] <= init_hash(3'(i));
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            last_pend_reg <= last_pend_next;
            count_reg     <= count_next;
            round_reg     <= round_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
            hash_reg      <= hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg   <= work_next;
        blk_reg    <= blk_next;
        digest_reg <= digest_next;
        index_reg  <= index_next;
        last_reg   <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign digest_word = digest_reg;
    assign word_index  = index_reg;
    assign last_word   = last_reg;

    // checks
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("engine state not one-hot");

    a_round_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_ROUND) |-> (round_reg == '0))
        else $error("round counter left running outside compression");

    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_reg == 7'(ROUNDS - 1)) |=> (state_reg == ST_FOLD))
        else $error("compression did not end after the last round");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (last_reg == (index_reg == 3'(DIGEST_WORDS - 1))))
        else $error("last word flag does not match word index");

    a_emit_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_EMIT) |-> (emit_idx_reg == '0))
        else $error("digest word counter not cleared");

endmodule

`default_nettype wire
